>>> rtl/core/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg
// Shared types and constants of the circular queue: field widths, operation
// and status codes, and the control word that steers each storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package cq_pkg;

    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 4;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ   = 2'd0,
        FUNC_DEQ   = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast to every cell in the chain each cycle.
    typedef struct packed {
        logic shift;   // take the word of the neighbor behind
        logic enq;     // the cell at the fill position loads the pushed word
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/circular_queue.sv
// ----------------------------------------------------------------------------
// circular_queue
// FIFO of signed 32-bit words holding at most DEPTH-1 entries, built as a
// chain of cells with the oldest word always in the first cell.
//
// Usage: each transfer on the input channel (func, push_value) carries one
// request: enqueue, dequeue, peek or clear. Each request produces exactly one
// transfer on the output channel with status, read_value, occupancy and
// is_empty. Requests are taken back to back as long as the output
// side keeps up: throughput is one request per cycle, and the result appears
// in the output register in the cycle after the request transfer. A dequeue
// moves every cell one step toward the head in that same cycle; an enqueue
// loads the cell at the current fill count. The single output register sets
// the pacing: while it holds a result that the receiver stalls, in_stall is
// raised and no request is taken. Reset empties the queue at once (the fill
// count returns to zero) and drops any pending result; cell contents are not
// cleared. occupancy is the fill count modulo 16.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue
    import cq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [FUNC_W-1:0]          func,
    input  wire logic signed [DATA_W-1:0]   push_value,

    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic [STATUS_W-1:0]        status,
    output      logic signed [DATA_W-1:0]   read_value,
    output      logic [OCC_W-1:0]           occupancy,
    output      logic                       is_empty
);

    localparam int NCELL = DEPTH - 1;
    localparam int CNT_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [OCC_W-1:0]         occupancy_reg;
    logic                     is_empty_reg;

    status_t                  status_next;
    logic signed [DATA_W-1:0] read_value_next;
    cell_ctrl_t               ctrl;
    logic                     in_fire;
    logic                     q_empty;
    logic                     q_full;

    logic signed [DATA_W-1:0] words [NCELL];

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == CNT_W'(DEPTH - 1));

    always_comb
    begin
        count_next      = count_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        ctrl            = '0;
        unique case (func_t'(func))
            FUNC_ENQ:
            begin
                if (q_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.enq   = in_fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FUNC_DEQ:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    read_value_next = words[0];
                    ctrl.shift      = in_fire;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            FUNC_PEEK:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    read_value_next = words[0];
                end
            end
            FUNC_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // The tail cell has no neighbor behind it and simply keeps its word.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] behind;
        if (i == NCELL - 1)
        begin : g_tail
            assign behind = words[i];
        end
        else
        begin : g_mid
            assign behind = words[i+1];
        end

        cq_cell #(
            .CNT_W (CNT_W),
            .POS   (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .push_word (push_value),
            .next_word (behind),
            .word      (words[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            occupancy_reg  <= OCC_W'(count_next);
            is_empty_reg   <= (count_next == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign occupancy  = occupancy_reg;
    assign is_empty   = is_empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH - 1))
        else $error("fill count beyond capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == FUNC_CLEAR) |=> (count_reg == '0 && is_empty_reg
            && status_reg == ST_OK && out_valid_reg))
        else $error("clear did not empty the queue");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == FUNC_ENQ && q_full) |=> (status_reg == ST_FULL
            && $stable(count_reg)))
        else $error("enqueue on full queue not refused");

    a_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (func == FUNC_DEQ || func == FUNC_PEEK) && q_empty)
            |=> (status_reg == ST_EMPTY && read_value_reg == '0
            && count_reg == '0))
        else $error("read of empty queue not refused");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(status_reg)
            && $stable(read_value_reg) && $stable(count_reg)))
        else $error("stalled result or queue state changed");

endmodule

`default_nettype wire

>>> rtl/core/cq_cell.sv
// ----------------------------------------------------------------------------
// cq_cell
// One storage cell of the queue chain. It either takes the word of its
// neighbor toward the tail, loads the pushed word when it is the fill
// position, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_cell
    import cq_pkg::*;
#(
    parameter int CNT_W = 4,
    parameter int POS   = 0
) (
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic [CNT_W-1:0]         count,
    input  wire logic signed [DATA_W-1:0] push_word,
    input  wire logic signed [DATA_W-1:0] next_word,
    output      logic signed [DATA_W-1:0] word
);

    logic signed [DATA_W-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            word_reg <= next_word;
        end
        else if (ctrl.enq && (count == CNT_W'(POS)))
        begin
            word_reg <= push_word;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire
